// File: hw/rtl/slwm_pkg.sv
// Shared types, constants and helper functions for the LIKE wildcard matcher.
// No dependencies; used by slwm_front, slwm_back and the top level.
package slwm_pkg;

  localparam int MaxTokens = 32;
  localparam int CntW      = $clog2(MaxTokens + 1);
  localparam int IdxW      = (MaxTokens > 1) ? $clog2(MaxTokens) : 1;
  localparam int CloseLvls = $clog2(MaxTokens + 1);

  localparam logic [7:0] ChrPercent   = 8'h25;
  localparam logic [7:0] ChrUnder     = 8'h5F;
  localparam logic [7:0] ChrBackslash = 8'h5C;
  localparam logic [7:0] ChrUpperA    = 8'h41;
  localparam logic [7:0] ChrUpperZ    = 8'h5A;
  localparam logic [7:0] CaseOffset   = 8'h20;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_APPEND  = 2'd1,
    KIND_SUBJECT = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    TOK_LIT = 2'd0,
    TOK_ONE = 2'd1,
    TOK_RUN = 2'd2
  } tok_t;

  typedef enum logic [1:0] {
    PC_PLAIN = 2'd0,
    PC_ESC   = 2'd1,
    PC_RUN   = 2'd2,
    PC_ONE   = 2'd3
  } pclass_t;

  typedef struct packed {
    tok_t       typ;
    logic [7:0] chr;
  } token_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_t      kind;
    pclass_t    pclass;
    logic [7:0] chr;
    logic       last;
  } op_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= ChrUpperA && c <= ChrUpperZ) ? c + CaseOffset : c;
  endfunction

  // Closes an active set over runs of '%': parallel prefix, log depth.
  // run[i] set: token i is a valid '%' token, so position i reaches i+1.
  function automatic logic [MaxTokens:0] close_runs(input logic [MaxTokens:0] seed,
                                                    input logic [MaxTokens-1:0] run);
    logic [MaxTokens:0] g;
    logic [MaxTokens:0] p;
    logic [MaxTokens:0] gq;
    logic [MaxTokens:0] pq;
    g = seed;
    p = {run, 1'b0};
    for (int l = 0; l < CloseLvls; l++) begin
      gq = g;
      pq = p;
      for (int i = 0; i <= MaxTokens; i++) begin
        if (i >= (1 << l)) begin
          g[i] = gq[i] | (pq[i] & gq[i - (1 << l)]);
          p[i] = pq[i] & pq[i - (1 << l)];
        end
      end
    end
    return g;
  endfunction

endpackage

// File: hw/rtl/sql_like_wildcard_matcher_top.sv
// Top level of the LIKE wildcard matcher: front classifier and back matcher.
// Depends on slwm_pkg, slwm_front, slwm_back.
//
//   channel | ports                  | accepted when
//   input   | push, full, in_item    | push && !full
//   result  | pop, empty, out_item   | pop && !empty
//
// One item per cycle sustained while the back end is not stalled; each subject
// byte updates the active set in the back end, and a result reaches the output
// ports through the front queue and then the result queue registers.
// Reset clears the pattern and leaves position zero active; the token store
// itself is not cleared. full rises when two classified items wait for the
// back end, which stalls only while both result entries are occupied.
module sql_like_wildcard_matcher_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  slwm_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output slwm_pkg::out_item_t out_item
);

  logic          op_valid;
  logic          op_take;
  slwm_pkg::op_t op;

  slwm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take)
  );

  slwm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// File: hw/rtl/slwm_front.sv
// Front end: accepts input items, folds case, classifies pattern bytes and
// queues them (two entries) for the back end. Depends on slwm_pkg.
module slwm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  slwm_pkg::in_item_t in_item,
  output logic               op_valid,
  output slwm_pkg::op_t      op,
  input  logic               op_take
);

  slwm_pkg::op_t q_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  slwm_pkg::op_t cls;
  logic          wr;
  logic          rd;

  always_comb begin
    cls.kind = slwm_pkg::kind_t'(in_item.kind);
    cls.chr  = slwm_pkg::fold_case(in_item.char_byte);
    cls.last = in_item.last;
    if (in_item.char_byte == slwm_pkg::ChrBackslash) begin
      cls.pclass = slwm_pkg::PC_ESC;
    end else if (in_item.char_byte == slwm_pkg::ChrPercent) begin
      cls.pclass = slwm_pkg::PC_RUN;
    end else if (in_item.char_byte == slwm_pkg::ChrUnder) begin
      cls.pclass = slwm_pkg::PC_ONE;
    end else begin
      cls.pclass = slwm_pkg::PC_PLAIN;
    end
  end

  assign full     = (cnt_r == 2'd2);
  assign op_valid = (cnt_r != 2'd0);
  assign op       = q_r[rp_r];
  assign wr       = push && !full;
  assign rd       = op_valid && op_take;

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// File: hw/rtl/slwm_back.sv
// Back end: token store, bit-parallel active set update with '%' closure,
// and a two-entry result queue. Depends on slwm_pkg.
module slwm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_valid,
  input  slwm_pkg::op_t       op,
  output logic                op_take,
  output logic                empty,
  input  logic                pop,
  output slwm_pkg::out_item_t out_item
);

  localparam int N = slwm_pkg::MaxTokens;

  slwm_pkg::token_t               store_r   [N];
  slwm_pkg::token_t               store_nxt [N];
  logic [slwm_pkg::CntW-1:0]      count_r, count_nxt;
  logic                           esc_r, esc_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [N:0]                     active_r, active_nxt;

  logic [N-1:0]                   run_cur;
  logic [N-1:0]                   run_nxt;
  logic [N-1:0]                   step_ok;
  logic [N:0]                     stepped;
  logic [N:0]                     adv;
  logic [N:0]                     restart_vec;
  logic [N:0]                     live_mask;
  logic [slwm_pkg::CntW-1:0]      ovw_pos;
  slwm_pkg::token_t               new_tok;
  logic                           hit;
  logic                           res_wr;
  slwm_pkg::out_item_t            res;

  slwm_pkg::out_item_t            rq_r [2];
  logic                           rwp_r, rwp_nxt;
  logic                           rrp_r, rrp_nxt;
  logic [1:0]                     rcnt_r, rcnt_nxt;
  logic                           rd;

  assign op_take = op_valid && (rcnt_r != 2'd2);

  // per-position decode of the current and next store
  always_comb begin
    for (int i = 0; i < N; i++) begin
      run_cur[i] = (store_r[i].typ == slwm_pkg::TOK_RUN) &&
                   (slwm_pkg::CntW'(i) < count_r);
      step_ok[i] = (slwm_pkg::CntW'(i) < count_r) &&
                   ((store_r[i].typ == slwm_pkg::TOK_ONE) ||
                    ((store_r[i].typ == slwm_pkg::TOK_LIT) && (store_r[i].chr == op.chr)));
      run_nxt[i] = (store_nxt[i].typ == slwm_pkg::TOK_RUN) &&
                   (slwm_pkg::CntW'(i) < count_nxt);
    end
    for (int i = 0; i <= N; i++) begin
      live_mask[i] = (slwm_pkg::CntW'(i) <= count_r);
    end
    stepped[0] = active_r[0] & run_cur[0];
    for (int j = 1; j <= N; j++) begin
      stepped[j] = (active_r[j - 1] & step_ok[j - 1]) |
                   ((j < N) ? (active_r[j] & run_cur[j]) : 1'b0);
    end
  end

  assign adv         = slwm_pkg::close_runs(stepped, run_cur);
  assign restart_vec = slwm_pkg::close_runs({{N{1'b0}}, 1'b1}, run_nxt);
  assign ovw_pos     = count_r - slwm_pkg::CntW'(1);

  // pattern load
  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    esc_nxt   = esc_r;
    ovf_nxt   = ovf_r;
    case (op.pclass)
      slwm_pkg::PC_RUN: new_tok = '{typ: slwm_pkg::TOK_RUN, chr: 8'h00};
      slwm_pkg::PC_ONE: new_tok = '{typ: slwm_pkg::TOK_ONE, chr: 8'h00};
      default:          new_tok = '{typ: slwm_pkg::TOK_LIT, chr: op.chr};
    endcase
    if (op_take) begin
      case (op.kind)
        slwm_pkg::KIND_CLEAR: begin
          count_nxt = '0;
          esc_nxt   = 1'b0;
          ovf_nxt   = 1'b0;
        end
        slwm_pkg::KIND_APPEND: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            if (count_r != '0) begin
              store_nxt[ovw_pos[slwm_pkg::IdxW-1:0]] = '{typ: slwm_pkg::TOK_LIT, chr: op.chr};
            end
          end else if (count_r >= slwm_pkg::CntW'(N)) begin
            ovf_nxt = 1'b1;
          end else begin
            esc_nxt   = (op.pclass == slwm_pkg::PC_ESC);
            store_nxt[count_r[slwm_pkg::IdxW-1:0]] = new_tok;
            count_nxt = count_r + slwm_pkg::CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // active set and result
  always_comb begin
    active_nxt = active_r;
    res_wr     = 1'b0;
    hit        = 1'b0;
    if (op_take) begin
      case (op.kind)
        slwm_pkg::KIND_SUBJECT: begin
          if (op.last) begin
            active_nxt = restart_vec;
            hit        = adv[count_r];
            res_wr     = 1'b1;
          end else begin
            active_nxt = adv;
          end
        end
        slwm_pkg::KIND_EMPTY: begin
          active_nxt = restart_vec;
          hit        = restart_vec[count_r];
          res_wr     = 1'b1;
        end
        default: begin
          active_nxt = restart_vec;
        end
      endcase
    end
    res.matched          = hit && !ovf_r;
    res.pattern_overflow = ovf_r;
  end

  // result queue
  assign empty    = (rcnt_r == 2'd0);
  assign out_item = rq_r[rrp_r];
  assign rd       = pop && !empty;

  always_comb begin
    rwp_nxt  = res_wr ? ~rwp_r : rwp_r;
    rrp_nxt  = rd ? ~rrp_r : rrp_r;
    rcnt_nxt = rcnt_r + {1'b0, res_wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      esc_r    <= 1'b0;
      ovf_r    <= 1'b0;
      active_r <= {{N{1'b0}}, 1'b1};
      rwp_r    <= 1'b0;
      rrp_r    <= 1'b0;
      rcnt_r   <= 2'd0;
    end else begin
      count_r  <= count_nxt;
      esc_r    <= esc_nxt;
      ovf_r    <= ovf_nxt;
      active_r <= active_nxt;
      rwp_r    <= rwp_nxt;
      rrp_r    <= rrp_nxt;
      rcnt_r   <= rcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
    if (res_wr) begin
      rq_r[rwp_r] <= res;
    end
  end

  a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r & ~live_mask) == '0)
    else $error("active position beyond token count");

  a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (op_take && op.kind == slwm_pkg::KIND_CLEAR) |=>
      (count_r == '0 && active_r == {{N{1'b0}}, 1'b1} && !ovf_r && !esc_r))
    else $error("clear did not restart matcher");

  a_esc_has_token: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (count_r != '0))
    else $error("escape pending without a stored token");

  a_no_match_on_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> !(res.matched && res.pattern_overflow))
    else $error("match reported with overflowed pattern");

endmodule
